/* src/kf3_pkg.sv */
// shared types and constants of the three-state altitude kalman filter
`timescale 1ns / 1ps

package kf3_pkg;

    // magnitude limit of every internal product and quotient (2^60)
    localparam logic [63:0] LIMIT = 64'h1000_0000_0000_0000;

    // multiplier digit size and digit count over a 64-bit magnitude
    localparam int MUL_DIG_BITS = 16;
    localparam int MUL_DIGS     = 4;

    // dividend bits of the gain divide: 48-bit magnitude shifted by 32
    localparam int DIV_BITS = 80;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
        logic clip;
    } t_unit_stat;

endpackage

/* src/kf3_mul.sv */
// iterative signed multiplier with round-to-nearest shift and magnitude clip
`timescale 1ns / 1ps

module kf3_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [63:0]      i_a,
    input  logic signed [63:0]      i_b,
    input  logic                    i_sh32,
    output kf3_pkg::t_unit_stat     o_stat,
    output logic signed [63:0]      o_res
);

    localparam int DW = kf3_pkg::MUL_DIG_BITS;
    localparam logic [2:0] STEP_RND = 3'(kf3_pkg::MUL_DIGS);
    localparam logic [2:0] STEP_FIN = 3'(kf3_pkg::MUL_DIGS + 1);

    logic               r_busy;
    logic               r_done;
    logic               r_clip;
    logic               r_neg;
    logic               r_sh32;
    logic [63:0]        r_ua;
    logic [63:0]        r_ub;
    logic [127:0]       r_acc;
    logic [2:0]         r_step;
    logic signed [63:0] r_res;

    logic [79:0]        w_part;
    logic [127:0]       w_add;
    logic [127:0]       w_half;
    logic [127:0]       w_q;
    logic               w_over;
    logic [63:0]        w_mag;

    assign w_part = r_ua * r_ub[DW-1:0];
    assign w_add  = {48'b0, w_part} << {r_step[1:0], 4'b0};
    assign w_half = r_sh32 ? 128'h8000_0000 : 128'h80_0000;
    assign w_q    = r_sh32 ? (r_acc >> 32) : (r_acc >> 24);
    assign w_over = (|w_q[127:61]) || (w_q[60] && (|w_q[59:0]));
    assign w_mag  = w_over ? kf3_pkg::LIMIT : {3'b0, w_q[60:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_clip <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_ua   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
                r_ub   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
                r_neg  <= i_a[63] ^ i_b[63];
                r_sh32 <= i_sh32;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_step < STEP_RND) begin
                    // one 16-bit digit of b per cycle
                    r_acc  <= r_acc + w_add;
                    r_ub   <= r_ub >> DW;
                    r_step <= r_step + 3'd1;
                end else if (r_step == STEP_RND) begin
                    r_acc  <= r_acc + w_half;
                    r_step <= STEP_FIN;
                end else begin
                    r_res  <= r_neg ? -$signed(w_mag) : $signed(w_mag);
                    r_clip <= w_over;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.clip = r_clip;
    assign o_res       = r_res;

endmodule

/* src/kf3_div.sv */
// restoring divider for the kalman gain, round to nearest, magnitude clip
`timescale 1ns / 1ps

module kf3_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [47:0]      i_num,
    input  logic [47:0]             i_den,
    output kf3_pkg::t_unit_stat     o_stat,
    output logic signed [63:0]      o_res
);

    localparam int NB = kf3_pkg::DIV_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic [CW-1:0] CNT_END = CW'(NB);

    logic               r_busy;
    logic               r_done;
    logic               r_clip;
    logic               r_neg;
    logic [NB-1:0]      r_dvd;
    logic [47:0]        r_rem;
    logic [NB-1:0]      r_q;
    logic [47:0]        r_den;
    logic [CW-1:0]      r_cnt;
    logic signed [63:0] r_res;

    logic [47:0]        w_u;
    logic [48:0]        w_rsh;
    logic [48:0]        w_diff;
    logic               w_ge;
    logic               w_over;
    logic [63:0]        w_mag;

    assign w_u    = i_num[47] ? 48'(-i_num) : 48'(i_num);
    assign w_rsh  = {r_rem, r_dvd[NB-1]};
    assign w_diff = w_rsh - {1'b0, r_den};
    assign w_ge   = w_rsh >= {1'b0, r_den};
    assign w_over = (|r_q[NB-1:61]) || (r_q[60] && (|r_q[59:0]));
    assign w_mag  = w_over ? kf3_pkg::LIMIT : {3'b0, r_q[60:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_clip <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[47];
                r_den  <= i_den;
                // numerator scaled by 2^32 plus half the divisor for rounding
                r_dvd  <= {w_u, 32'b0} + NB'(i_den >> 1);
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                if (r_cnt != CNT_END) begin
                    r_rem <= w_ge ? w_diff[47:0] : w_rsh[47:0];
                    r_q   <= {r_q[NB-2:0], w_ge};
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_res  <= r_neg ? -$signed(w_mag) : $signed(w_mag);
                    r_clip <= w_over;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.clip = r_clip;
    assign o_res       = r_res;

endmodule

/* src/altitude_kalman_filter_3state_core.sv */
// three-state altitude kalman filter: sequencer, state, covariance and config registers
// operations: init loads the state directly; predict runs 10 multiplies, an update
//   3 gain divides on the shared divider plus 12 multiplies; the divider produces one
//   quotient bit per cycle
// throughput: one item at a time; the next transfer is taken once the last result is
//   in the output register, while that result may still wait to be taken
// reset: synchronous active low; estimates go to zero, covariance to a diagonal of the
//   init_var reset value, configuration registers to their defaults
`timescale 1ns / 1ps

module altitude_kalman_filter_3state_core #(
    parameter int STATE_FRAC_BITS = 16,
    parameter int COV_FRAC_BITS   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input stream
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    // [31:0] accel, [63:32] altitude_meas, [95:64] speed_meas,
    // [127:96] start_altitude, [159:128] start_speed, [191:160] start_bias
    input  logic [191:0]    i_s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]      i_s_axis_tuser,
    // result stream
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    // [31:0] altitude_est, [63:32] speed_est, [95:64] bias_est
    output logic [95:0]     o_m_axis_tdata,
    // [0] saturated
    output logic            o_m_axis_tuser,
    // configuration write channel
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [46:0]     i_cfg_data
);

    // register reset values follow the fixed point formats
    localparam logic [63:0] GRAV_RST  = ((64'd981 << STATE_FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [63:0] NALT_RST  = ((64'd1 << COV_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] NBIAS_RST = ((64'd1 << COV_FRAC_BITS) + 64'd50000) / 64'd100000;
    localparam logic [63:0] RN_RST    = 64'd2 << COV_FRAC_BITS;
    localparam logic [63:0] IVAR_RST  = 64'd10 << COV_FRAC_BITS;
    localparam logic [23:0] DT_RST    = 24'd32768;

    // configuration register indexes
    localparam logic [2:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [2:0] CFG_GRAVITY     = 3'd1;
    localparam logic [2:0] CFG_NOISE_ALT   = 3'd2;
    localparam logic [2:0] CFG_NOISE_SPD   = 3'd3;
    localparam logic [2:0] CFG_NOISE_BIAS  = 3'd4;
    localparam logic [2:0] CFG_MEAS_NOISE  = 3'd5;
    localparam logic [2:0] CFG_INIT_VAR    = 3'd6;

    // operation modes
    localparam logic [1:0] MODE_PRED = 2'd0;
    localparam logic [1:0] MODE_ALT  = 2'd1;
    localparam logic [1:0] MODE_SPD  = 2'd2;
    localparam logic [1:0] MODE_INIT = 2'd3;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_CMT   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // micro-op kinds and destinations
    localparam logic [1:0] K_ADD = 2'd0;
    localparam logic [1:0] K_MUL = 2'd1;
    localparam logic [1:0] K_DIV = 2'd2;
    localparam logic [1:0] DK_X  = 2'd0;
    localparam logic [1:0] DK_T  = 2'd1;
    localparam logic [1:0] DK_N  = 2'd2;

    localparam logic [3:0] OP_LAST_PRED = 4'd14;
    localparam logic [3:0] OP_LAST_UPD  = 4'd15;

    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] S48_MIN = 64'shFFFF_8000_0000_0000;

    function automatic logic signed [63:0] f_sx32(input logic [31:0] v);
        f_sx32 = $signed({{32{v[31]}}, v});
    endfunction

    function automatic logic signed [63:0] f_sx48(input logic [47:0] v);
        f_sx48 = $signed({{16{v[47]}}, v});
    endfunction

    // configuration registers
    logic [23:0]        r_dt;
    logic [30:0]        r_grav;
    logic [39:0]        r_nalt;
    logic [39:0]        r_nspd;
    logic [39:0]        r_nbias;
    logic [46:0]        r_rnoise;
    logic [46:0]        r_ivar;

    // filter state
    logic signed [31:0] r_alt;
    logic signed [31:0] r_spd;
    logic signed [31:0] r_bias;
    logic signed [47:0] r_p [0:8];

    // working registers: new covariance, temporaries (gains, y, dt products)
    logic signed [47:0] r_n [0:8];
    logic signed [63:0] r_t [0:3];
    logic [2:0]         r_state;
    logic [3:0]         r_op;
    logic [1:0]         r_mode;
    logic               r_h;
    logic [31:0]        r_arg;
    logic               r_sat;

    // output register
    logic               r_ovalid;
    logic [31:0]        r_o_alt;
    logic [31:0]        r_o_spd;
    logic [31:0]        r_o_bias;
    logic               r_o_sat;

    // decoded micro-op
    logic [1:0]         d_kind;
    logic signed [63:0] d_a;
    logic signed [63:0] d_b;
    logic               d_sh32;
    logic [1:0]         d_dk;
    logic [3:0]         d_di;
    logic signed [63:0] d_c;
    logic signed [63:0] d_e;
    logic               d_sub;

    kf3_pkg::t_unit_stat w_mul_st;
    kf3_pkg::t_unit_stat w_div_st;
    logic signed [63:0] w_mul_res;
    logic signed [63:0] w_div_res;
    logic               w_mul_start;
    logic               w_div_start;

    logic signed [48:0] w_s;
    logic               w_s_np;
    logic               w_skip;
    logic signed [63:0] w_r;
    logic signed [63:0] w_v;
    logic               w_ov32;
    logic               w_ov48;
    logic [31:0]        w_x32;
    logic [47:0]        w_x48;
    logic               w_unit_clip;
    logic               w_done;
    logic               w_wb_en;
    logic [3:0]         w_last;
    logic               w_in_xfer;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    // configuration writes, taken every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= DT_RST;
            r_grav   <= GRAV_RST[30:0];
            r_nalt   <= NALT_RST[39:0];
            r_nspd   <= NALT_RST[39:0];
            r_nbias  <= NBIAS_RST[39:0];
            r_rnoise <= RN_RST[46:0];
            r_ivar   <= IVAR_RST[46:0];
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIME_STEP:  r_dt     <= i_cfg_data[23:0];
                CFG_GRAVITY:    r_grav   <= i_cfg_data[30:0];
                CFG_NOISE_ALT:  r_nalt   <= i_cfg_data[39:0];
                CFG_NOISE_SPD:  r_nspd   <= i_cfg_data[39:0];
                CFG_NOISE_BIAS: r_nbias  <= i_cfg_data[39:0];
                CFG_MEAS_NOISE: r_rnoise <= i_cfg_data;
                CFG_INIT_VAR:   r_ivar   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // micro-op decode: predict steps, or the update steps for row h
    always_comb begin
        d_kind = K_ADD;
        d_a    = '0;
        d_b    = '0;
        d_sh32 = 1'b0;
        d_dk   = DK_T;
        d_di   = '0;
        d_c    = '0;
        d_e    = '0;
        d_sub  = 1'b0;
        if (r_mode == MODE_PRED) begin
            d_b = $signed({40'b0, r_dt});
            case (r_op)
                4'd0: begin  // altitude += dt*speed
                    d_kind = K_MUL; d_a = f_sx32(r_spd); d_dk = DK_X; d_di = 4'd0;
                    d_c = f_sx32(r_alt);
                end
                4'd1: begin  // speed += dt*(accel + gravity - bias)
                    d_kind = K_MUL; d_dk = DK_X; d_di = 4'd1;
                    d_a = f_sx32(r_arg) + $signed({33'b0, r_grav}) - f_sx32(r_bias);
                    d_c = f_sx32(r_spd);
                end
                4'd2: begin d_kind = K_MUL; d_a = f_sx48(r_p[4]); d_di = 4'd0; end
                4'd3: begin d_kind = K_MUL; d_a = f_sx48(r_p[5]); d_di = 4'd1; end
                4'd4: begin d_kind = K_MUL; d_a = f_sx48(r_p[7]); d_di = 4'd2; end
                4'd5: begin d_kind = K_MUL; d_a = f_sx48(r_p[8]); d_di = 4'd3; end
                4'd6: begin
                    d_kind = K_MUL; d_dk = DK_N; d_di = 4'd0;
                    d_a = f_sx48(r_p[3]) + f_sx48(r_p[1]) + r_t[0];
                    d_c = f_sx48(r_p[0]); d_e = $signed({24'b0, r_nalt});
                end
                4'd7: begin
                    d_kind = K_MUL; d_dk = DK_N; d_di = 4'd1;
                    d_a = f_sx48(r_p[4]) - f_sx48(r_p[2]) - r_t[1];
                    d_c = f_sx48(r_p[1]);
                end
                4'd8: begin d_dk = DK_N; d_di = 4'd2; d_c = f_sx48(r_p[2]); d_e = r_t[1]; end
                4'd9: begin
                    d_kind = K_MUL; d_dk = DK_N; d_di = 4'd3;
                    d_a = f_sx48(r_p[4]) - f_sx48(r_p[6]) - r_t[2];
                    d_c = f_sx48(r_p[3]);
                end
                4'd10: begin
                    d_kind = K_MUL; d_dk = DK_N; d_di = 4'd4;
                    d_a = f_sx48(r_p[8]) - f_sx48(r_p[7]) - f_sx48(r_p[5]);
                    d_a = d_a + r_t[3] - f_sx48(r_p[8]);
                    d_c = f_sx48(r_p[4]); d_e = $signed({24'b0, r_nspd});
                end
                4'd11: begin d_dk = DK_N; d_di = 4'd5; d_c = f_sx48(r_p[5]); d_e = -r_t[3]; end
                4'd12: begin d_dk = DK_N; d_di = 4'd6; d_c = f_sx48(r_p[6]); d_e = r_t[2]; end
                4'd13: begin d_dk = DK_N; d_di = 4'd7; d_c = f_sx48(r_p[7]); d_e = -r_t[3]; end
                4'd14: begin
                    d_dk = DK_N; d_di = 4'd8; d_c = f_sx48(r_p[8]);
                    d_e = $signed({24'b0, r_nbias});
                end
                default: ;
            endcase
        end else begin
            d_sh32 = 1'b1;
            case (r_op)
                4'd0: begin  // innovation y
                    d_di = 4'd3; d_c = f_sx32(r_arg);
                    d_e = -(r_h ? f_sx32(r_spd) : f_sx32(r_alt));
                end
                4'd1: begin
                    d_kind = K_DIV; d_di = 4'd0; d_a = f_sx48(r_h ? r_p[1] : r_p[0]);
                end
                4'd2: begin
                    d_kind = K_DIV; d_di = 4'd1; d_a = f_sx48(r_h ? r_p[4] : r_p[3]);
                end
                4'd3: begin
                    d_kind = K_DIV; d_di = 4'd2; d_a = f_sx48(r_h ? r_p[7] : r_p[6]);
                end
                4'd4: begin
                    d_kind = K_MUL; d_a = r_t[0]; d_b = r_t[3]; d_dk = DK_X; d_di = 4'd0;
                    d_c = f_sx32(r_alt);
                end
                4'd5: begin
                    d_kind = K_MUL; d_a = r_t[1]; d_b = r_t[3]; d_dk = DK_X; d_di = 4'd1;
                    d_c = f_sx32(r_spd);
                end
                4'd6: begin
                    d_kind = K_MUL; d_a = r_t[2]; d_b = r_t[3]; d_dk = DK_X; d_di = 4'd2;
                    d_c = f_sx32(r_bias);
                end
                default: begin
                    // covariance rows: P[i][j] -= K[i]*P[h][j]
                    for (int i = 0; i < 3; i++) begin
                        for (int j = 0; j < 3; j++) begin
                            if (r_op == 4'(7 + 3 * i + j)) begin
                                d_kind = K_MUL;
                                d_a    = r_t[i];
                                d_b    = f_sx48(r_h ? r_p[3 + j] : r_p[j]);
                                d_dk   = DK_N;
                                d_di   = 4'(3 * i + j);
                                d_c    = f_sx48(r_p[3 * i + j]);
                                d_sub  = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // innovation variance; update is dropped when it is not positive
    assign w_s    = $signed({(r_h ? r_p[4][47] : r_p[0][47]), (r_h ? r_p[4] : r_p[0])})
                  + $signed({2'b0, r_rnoise});
    assign w_s_np = w_s[48] || (w_s == '0);
    assign w_skip = (r_state == ST_ISSUE) && (r_mode != MODE_PRED) && (r_op == '0) && w_s_np;

    assign w_mul_start = (r_state == ST_ISSUE) && (d_kind == K_MUL);
    assign w_div_start = (r_state == ST_ISSUE) && (d_kind == K_DIV);

    kf3_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (d_a),
        .i_b     (d_b),
        .i_sh32  (d_sh32),
        .o_stat  (w_mul_st),
        .o_res   (w_mul_res)
    );

    kf3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (d_a[47:0]),
        .i_den   (w_s[47:0]),
        .o_stat  (w_div_st),
        .o_res   (w_div_res)
    );

    // writeback value: c + e +/- unit result, then clip to the destination
    assign w_r = (d_kind == K_MUL) ? w_mul_res :
                 (d_kind == K_DIV) ? w_div_res : 64'sd0;
    assign w_v = d_c + d_e + (d_sub ? -w_r : w_r);
    assign w_ov32 = (w_v > S32_MAX) || (w_v < S32_MIN);
    assign w_ov48 = (w_v > S48_MAX) || (w_v < S48_MIN);
    assign w_x32  = (w_v > S32_MAX) ? S32_MAX[31:0] :
                    (w_v < S32_MIN) ? S32_MIN[31:0] : w_v[31:0];
    assign w_x48  = (w_v > S48_MAX) ? S48_MAX[47:0] :
                    (w_v < S48_MIN) ? S48_MIN[47:0] : w_v[47:0];
    assign w_unit_clip = ((d_kind == K_MUL) && w_mul_st.clip) ||
                         ((d_kind == K_DIV) && w_div_st.clip);
    assign w_done  = w_mul_st.done || w_div_st.done;
    assign w_wb_en = ((r_state == ST_ISSUE) && (d_kind == K_ADD) && !w_skip) ||
                     ((r_state == ST_WAIT) && w_done);
    assign w_last  = (r_mode == MODE_PRED) ? OP_LAST_PRED : OP_LAST_UPD;

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= '0;
            r_ovalid <= 1'b0;
            r_sat    <= 1'b0;
            r_alt    <= '0;
            r_spd    <= '0;
            r_bias   <= '0;
            for (int i = 0; i < 9; i++) begin
                r_p[i] <= (i % 4 == 0) ? {1'b0, IVAR_RST[46:0]} : '0;
            end
        end else begin
            // result taken; the finish state reloads the register itself
            if (r_ovalid && i_m_axis_tready && (r_state != ST_FIN)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_op  <= '0;
                        r_sat <= 1'b0;
                        if (i_s_axis_tuser == MODE_INIT) begin
                            // re-init: load state, covariance to diag(init_var)
                            r_alt  <= i_s_axis_tdata[127:96];
                            r_spd  <= i_s_axis_tdata[159:128];
                            r_bias <= i_s_axis_tdata[191:160];
                            for (int i = 0; i < 9; i++) begin
                                r_p[i] <= (i % 4 == 0) ? {1'b0, r_ivar} : '0;
                            end
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    if (w_skip) begin
                        r_sat   <= 1'b1;
                        r_state <= ST_FIN;
                    end else if (d_kind == K_ADD) begin
                        if (r_op == w_last) begin
                            r_state <= ST_CMT;
                        end else begin
                            r_op <= r_op + 4'd1;
                        end
                    end else begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_done) begin
                        if (r_op == w_last) begin
                            r_state <= ST_CMT;
                        end else begin
                            r_op    <= r_op + 4'd1;
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_CMT: begin
                    // new covariance replaces the old one at once
                    for (int i = 0; i < 9; i++) begin
                        r_p[i] <= r_n[i];
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_wb_en) begin
                if (d_dk == DK_X) begin
                    case (d_di)
                        4'd0:    r_alt  <= w_x32;
                        4'd1:    r_spd  <= w_x32;
                        default: r_bias <= w_x32;
                    endcase
                end
                r_sat <= r_sat || w_unit_clip || ((d_dk == DK_X) && w_ov32) ||
                         ((d_dk == DK_N) && w_ov48);
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_mode <= i_s_axis_tuser;
            r_h    <= (i_s_axis_tuser == MODE_SPD);
            case (i_s_axis_tuser)
                MODE_PRED: r_arg <= i_s_axis_tdata[31:0];
                MODE_ALT:  r_arg <= i_s_axis_tdata[63:32];
                default:   r_arg <= i_s_axis_tdata[95:64];
            endcase
        end
        if (w_wb_en) begin
            for (int i = 0; i < 4; i++) begin
                if ((d_dk == DK_T) && (d_di == 4'(i))) begin
                    r_t[i] <= w_v;
                end
            end
            for (int i = 0; i < 9; i++) begin
                if ((d_dk == DK_N) && (d_di == 4'(i))) begin
                    r_n[i] <= w_x48;
                end
            end
        end
        if ((r_state == ST_FIN) && (!r_ovalid || i_m_axis_tready)) begin
            r_o_alt  <= r_alt;
            r_o_spd  <= r_spd;
            r_o_bias <= r_bias;
            r_o_sat  <= r_sat;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_o_bias, r_o_spd, r_o_alt};
    assign o_m_axis_tuser  = r_o_sat;

    // the two arithmetic units never run at the same time
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_st.busy && w_div_st.busy))
        else $error("multiplier and divider busy together");

    // a unit result only arrives while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_WAIT))
        else $error("unit result outside wait state");

    // an accepted item always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state != ST_IDLE))
        else $error("transfer accepted but sequencer stayed idle");

    // re-init never reports saturation
    a_init_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && (r_mode == MODE_INIT)) |-> !r_sat)
        else $error("saturation flagged on re-init");

    // micro-op counter stays within the update program
    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op <= OP_LAST_UPD)
        else $error("micro-op counter out of range");

endmodule
